// ----- hw/rtl/dpr_pkg.sv -----
// Shared types and constants for the debugger packet receiver.
// No dependencies; every other RTL file of the block refers to this package by scoped names.
`timescale 1ns / 1ps
`default_nettype none

package dpr_pkg;

   // Sizing of the internal counters
   localparam int LENGTH_BITS  = 12;
   localparam int IDLE_BITS    = 20;

   // Configuration register widths and indexes
   localparam int BUF_SIZE_W   = 13;
   localparam int IDLE_LIMIT_W = 20;
   localparam int CSR_INDEX_W  = 1;
   localparam int CSR_DATA_W   = 20;

   localparam logic [CSR_INDEX_W-1:0] CSR_BUFFER_SIZE = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_IDLE_LIMIT  = 1'b1;

   localparam logic [BUF_SIZE_W-1:0]   BUF_SIZE_RESET   = 13'd1024;
   localparam logic [IDLE_LIMIT_W-1:0] IDLE_LIMIT_RESET = 20'd1000000;

   // Largest counter values
   localparam logic [LENGTH_BITS-1:0] LEN_MAX  = {LENGTH_BITS{1'b1}};
   localparam logic [IDLE_BITS-1:0]   IDLE_MAX = {IDLE_BITS{1'b1}};

   // Framing characters
   localparam logic [7:0] CTRL_C_CH = 8'h03;
   localparam logic [7:0] START_CH  = 8'h24;
   localparam logic [7:0] END_CH    = 8'h23;
   localparam logic [7:0] ACK_CH    = 8'h2B;
   localparam logic [7:0] NACK_CH   = 8'h2D;
   localparam logic [3:0] HEX_TEN   = 4'd10;

   // Queue between front and back
   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [0:0] {
      OP_BYTE = 1'b0,
      OP_IDLE = 1'b1
   } opcode_type;

   typedef enum logic [2:0] {
      EV_PAYLOAD   = 3'd0,
      EV_OK        = 3'd1,
      EV_MISMATCH  = 3'd2,
      EV_BAD_HEX   = 3'd3,
      EV_OVERFLOW  = 3'd4,
      EV_INTERRUPT = 3'd5,
      EV_TIMEOUT   = 3'd6
   } event_kind_type;

   typedef enum logic [2:0] {
      CLS_IDLE,
      CLS_CTRLC,
      CLS_START,
      CLS_END,
      CLS_OTHER
   } byte_class_type;

   typedef enum logic [1:0] {
      PH_HUNT = 2'd0,
      PH_DATA = 2'd1,
      PH_SUM  = 2'd2
   } phase_type;

   typedef struct packed {
      opcode_type  opcode;
      logic [7:0]  rx_byte;
   } req_type;

   typedef struct packed {
      event_kind_type          event_kind;
      logic [7:0]              payload_byte;
      logic [LENGTH_BITS-1:0]  payload_length;
      logic                    reply_valid;
      logic [7:0]              reply_byte;
      logic [7:0]              sum_computed;
      logic [7:0]              sum_received;
   } rsp_type;

   // One classified item as it travels from front to back
   typedef struct packed {
      byte_class_type  cls;
      logic            hex_ok;
      logic [3:0]      hex_val;
      logic [7:0]      data;
   } item_type;

   typedef struct packed {
      logic [BUF_SIZE_W-1:0]    buffer_size;
      logic [IDLE_LIMIT_W-1:0]  idle_limit;
   } cfg_type;

endpackage

`default_nettype wire

// ----- hw/rtl/dpr_front.sv -----
// Front end: classifies each incoming item (idle tick, Ctrl-C, framing character,
// hex digit) for the back end. Depends on dpr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dpr_front (
   input  wire dpr_pkg::req_type   req_data,
   output dpr_pkg::item_type       item
);

   logic [7:0] ch;

   assign ch = req_data.rx_byte;

   // Byte class
   always_comb begin
      item.data = ch;
      if (req_data.opcode == dpr_pkg::OP_IDLE) begin
         item.cls = dpr_pkg::CLS_IDLE;
      end else if (ch == dpr_pkg::CTRL_C_CH) begin
         item.cls = dpr_pkg::CLS_CTRLC;
      end else if (ch == dpr_pkg::START_CH) begin
         item.cls = dpr_pkg::CLS_START;
      end else if (ch == dpr_pkg::END_CH) begin
         item.cls = dpr_pkg::CLS_END;
      end else begin
         item.cls = dpr_pkg::CLS_OTHER;
      end
   end

   // Hex digit decode, either letter case
   always_comb begin
      item.hex_ok  = 1'b1;
      item.hex_val = 4'd0;
      if (ch >= 8'h30 && ch <= 8'h39) begin
         item.hex_val = ch[3:0];
      end else if ((ch >= 8'h61 && ch <= 8'h66) || (ch >= 8'h41 && ch <= 8'h46)) begin
         item.hex_val = 4'(ch[2:0] - 3'd1) + dpr_pkg::HEX_TEN;
      end else begin
         item.hex_ok = 1'b0;
      end
   end

endmodule

`default_nettype wire

// ----- hw/rtl/dpr_queue.sv -----
// Short queue of classified items between front and back end.
// Depends on dpr_pkg for the item type and depth.
`timescale 1ns / 1ps
`default_nettype none

module dpr_queue (
   input  wire                       clock,
   input  wire                       reset,
   input  wire                       push,
   input  wire dpr_pkg::item_type    push_item,
   output logic                      full,
   input  wire                       pop,
   output logic                      not_empty,
   output dpr_pkg::item_type         pop_item
);

   dpr_pkg::item_type entry_ff [dpr_pkg::QUEUE_DEPTH];

   logic [dpr_pkg::QUEUE_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [dpr_pkg::QUEUE_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [dpr_pkg::QUEUE_CNT_W-1:0] count_ff, count_in;

   localparam logic [dpr_pkg::QUEUE_PTR_W-1:0] LAST_PTR =
      dpr_pkg::QUEUE_PTR_W'(dpr_pkg::QUEUE_DEPTH - 1);
   localparam logic [dpr_pkg::QUEUE_CNT_W-1:0] FULL_COUNT =
      dpr_pkg::QUEUE_CNT_W'(dpr_pkg::QUEUE_DEPTH);

   assign full      = (count_ff == FULL_COUNT);
   assign not_empty = (count_ff != '0);
   assign pop_item  = entry_ff[rd_ptr_ff];

   // Pointer and occupancy update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Storage, no reset
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

`default_nettype wire

// ----- hw/rtl/dpr_back.sv -----
// Back end: packet phase machine, payload sum, checksum check, idle timer and
// the result register. Depends on dpr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dpr_back (
   input  wire                       clock,
   input  wire                       reset,
   input  wire dpr_pkg::cfg_type     cfg,
   input  wire                       item_valid,
   input  wire dpr_pkg::item_type    item,
   output logic                      pop,
   output logic                      rsp_valid,
   input  wire                       rsp_stall,
   output dpr_pkg::rsp_type          rsp_data
);

   dpr_pkg::phase_type phase_ff, phase_in;

   logic [dpr_pkg::LENGTH_BITS-1:0] byte_count_ff, byte_count_in;
   logic [7:0]                      running_sum_ff, running_sum_in;
   logic [7:0]                      digit_acc_ff, digit_acc_in;
   logic                            digits_seen_ff, digits_seen_in;
   logic [dpr_pkg::IDLE_BITS-1:0]   idle_count_ff, idle_count_in;
   logic                            rsp_valid_ff, rsp_valid_in;
   dpr_pkg::rsp_type                rsp_data_ff, rsp_data_in;

   logic                            take;
   logic                            emit;
   logic                            hunt_clear;
   logic [7:0]                      acc_next;
   logic [dpr_pkg::BUF_SIZE_W-1:0]  buf_lim;
   logic [31:0]                     len_lim;
   logic [31:0]                     idle_lim_wide;
   logic [dpr_pkg::IDLE_BITS-1:0]   idle_lim;
   dpr_pkg::rsp_type                result;

   // Payload limit: buffer_size - 1, floored at zero and capped by the counter
   always_comb begin
      buf_lim = (cfg.buffer_size == '0) ? '0 : cfg.buffer_size - 1'b1;
      len_lim = (32'(buf_lim) > 32'(dpr_pkg::LEN_MAX)) ? 32'(dpr_pkg::LEN_MAX)
                                                       : 32'(buf_lim);
   end

   // Idle limit saturated at the counter range
   always_comb begin
      idle_lim_wide = (32'(cfg.idle_limit) > 32'(dpr_pkg::IDLE_MAX))
                      ? 32'(dpr_pkg::IDLE_MAX) : 32'(cfg.idle_limit);
      idle_lim      = idle_lim_wide[dpr_pkg::IDLE_BITS-1:0];
   end

   assign take     = !rsp_valid_ff || !rsp_stall;
   assign pop      = item_valid && take;
   assign acc_next = {digit_acc_ff[3:0], item.hex_val};

   // Next phase, counters and the result for the item at the head of the queue
   always_comb begin
      phase_in       = phase_ff;
      byte_count_in  = byte_count_ff;
      running_sum_in = running_sum_ff;
      digit_acc_in   = digit_acc_ff;
      digits_seen_in = digits_seen_ff;
      idle_count_in  = idle_count_ff;
      emit           = 1'b0;
      hunt_clear     = 1'b0;
      result         = '0;

      if (pop) begin
         if (item.cls == dpr_pkg::CLS_IDLE) begin
            if (idle_count_ff >= idle_lim) begin
               emit              = 1'b1;
               result.event_kind = dpr_pkg::EV_TIMEOUT;
               idle_count_in     = '0;
               hunt_clear        = 1'b1;
            end else begin
               idle_count_in = idle_count_ff + 1'b1;
            end
         end else begin
            idle_count_in = '0;
            if (item.cls == dpr_pkg::CLS_CTRLC) begin
               emit              = 1'b1;
               result.event_kind = dpr_pkg::EV_INTERRUPT;
               hunt_clear        = 1'b1;
            end else begin
               case (phase_ff)
                  dpr_pkg::PH_DATA: begin
                     if (item.cls == dpr_pkg::CLS_END) begin
                        phase_in       = dpr_pkg::PH_SUM;
                        digits_seen_in = 1'b0;
                        digit_acc_in   = '0;
                     end else if (32'(byte_count_ff) < len_lim) begin
                        byte_count_in       = byte_count_ff + 1'b1;
                        running_sum_in      = running_sum_ff + item.data;
                        emit                = 1'b1;
                        result.event_kind   = dpr_pkg::EV_PAYLOAD;
                        result.payload_byte = item.data;
                     end else begin
                        emit               = 1'b1;
                        result.event_kind  = dpr_pkg::EV_OVERFLOW;
                        result.reply_valid = 1'b1;
                        result.reply_byte  = dpr_pkg::NACK_CH;
                        hunt_clear         = 1'b1;
                     end
                  end
                  dpr_pkg::PH_SUM: begin
                     if (!item.hex_ok) begin
                        emit               = 1'b1;
                        result.event_kind  = dpr_pkg::EV_BAD_HEX;
                        result.reply_valid = 1'b1;
                        result.reply_byte  = dpr_pkg::NACK_CH;
                        hunt_clear         = 1'b1;
                     end else if (!digits_seen_ff) begin
                        digit_acc_in   = acc_next;
                        digits_seen_in = 1'b1;
                     end else begin
                        emit                = 1'b1;
                        result.reply_valid  = 1'b1;
                        result.sum_received = acc_next;
                        if (acc_next == running_sum_ff) begin
                           result.event_kind = dpr_pkg::EV_OK;
                           result.reply_byte = dpr_pkg::ACK_CH;
                        end else begin
                           result.event_kind = dpr_pkg::EV_MISMATCH;
                           result.reply_byte = dpr_pkg::NACK_CH;
                        end
                        hunt_clear = 1'b1;
                     end
                  end
                  default: begin
                     // hunting, and the unused phase code
                     if (item.cls == dpr_pkg::CLS_START) begin
                        phase_in       = dpr_pkg::PH_DATA;
                        byte_count_in  = '0;
                        running_sum_in = '0;
                        digit_acc_in   = '0;
                        digits_seen_in = 1'b0;
                     end else begin
                        phase_in = dpr_pkg::PH_HUNT;
                     end
                  end
               endcase
            end
         end
      end

      // Report the counts as they stand before an end event clears them
      result.payload_length = byte_count_in;
      result.sum_computed   = running_sum_in;

      if (hunt_clear) begin
         phase_in       = dpr_pkg::PH_HUNT;
         byte_count_in  = '0;
         running_sum_in = '0;
         digit_acc_in   = '0;
         digits_seen_in = 1'b0;
      end
   end

   // Result register: refilled whenever the slot is free or being taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (take) begin
         rsp_valid_in = emit;
         if (emit) begin
            rsp_data_in = result;
         end
      end
   end

   // Phase register
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= dpr_pkg::PH_HUNT;
      end else begin
         phase_ff <= phase_in;
      end
   end

   // Packet and idle state
   always_ff @(posedge clock) begin
      if (reset) begin
         byte_count_ff  <= '0;
         running_sum_ff <= '0;
         digit_acc_ff   <= '0;
         digits_seen_ff <= 1'b0;
         idle_count_ff  <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         byte_count_ff  <= byte_count_in;
         running_sum_ff <= running_sum_in;
         digit_acc_ff   <= digit_acc_in;
         digits_seen_ff <= digits_seen_in;
         idle_count_ff  <= idle_count_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire

// ----- hw/rtl/debug_packet_receiver.sv -----
// Top level of the debugger packet receiver: configuration registers, front end,
// item queue and back end. Depends on dpr_pkg, dpr_front, dpr_queue and dpr_back.
`timescale 1ns / 1ps
`default_nettype none

// Deframes $payload#hh debugger packets from a stream of received bytes and
// idle ticks. Each transfer on req_ gives zero or one transfer on rsp_: one
// event per payload byte, one end event per packet (ok, checksum mismatch,
// bad hex digit, overflow) carrying the '+' or '-' reply byte, and interrupt
// (Ctrl-C) or timeout events. The block takes one item per clock while
// req_stall is low (item queue not full); each item waits in the two-entry
// item queue, and the back end registers its result before it is presented.
// The back end's output register is the only point at which rsp_stall
// holds work back. Write buffer_size (index 0) and idle_limit (index 1)
// through csr_ only while no item is in flight; writes are always taken
// (csr_ready is tied high). No clearing pass after reset.
module debug_packet_receiver (
   input  wire                                   clock,
   input  wire                                   reset,
   // item input
   input  wire                                   req_valid,
   output logic                                  req_stall,
   input  wire dpr_pkg::req_type                 req_data,
   // result output
   output logic                                  rsp_valid,
   input  wire                                   rsp_stall,
   output dpr_pkg::rsp_type                      rsp_data,
   // register writes
   input  wire                                   csr_valid,
   output logic                                  csr_ready,
   input  wire [dpr_pkg::CSR_INDEX_W-1:0]        csr_index,
   input  wire [dpr_pkg::CSR_DATA_W-1:0]         csr_wdata
);

   dpr_pkg::cfg_type   cfg_ff, cfg_in;
   dpr_pkg::item_type  front_item;
   dpr_pkg::item_type  head_item;
   logic               queue_full;
   logic               queue_not_empty;
   logic               queue_pop;
   logic               req_transfer;

   assign csr_ready    = 1'b1;
   assign req_stall    = queue_full;
   assign req_transfer = req_valid && !req_stall;

   // Configuration registers
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            dpr_pkg::CSR_BUFFER_SIZE: cfg_in.buffer_size = csr_wdata[dpr_pkg::BUF_SIZE_W-1:0];
            dpr_pkg::CSR_IDLE_LIMIT:  cfg_in.idle_limit  = csr_wdata[dpr_pkg::IDLE_LIMIT_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.buffer_size <= dpr_pkg::BUF_SIZE_RESET;
         cfg_ff.idle_limit  <= dpr_pkg::IDLE_LIMIT_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   dpr_front u_front (
      .req_data  (req_data),
      .item      (front_item)
   );

   dpr_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (req_transfer),
      .push_item (front_item),
      .full      (queue_full),
      .pop       (queue_pop),
      .not_empty (queue_not_empty),
      .pop_item  (head_item)
   );

   dpr_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .item_valid (queue_not_empty),
      .item       (head_item),
      .pop        (queue_pop),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_data   (rsp_data)
   );

   // Reply byte goes with the packet end events only
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.reply_valid ==
         (rsp_data.event_kind == dpr_pkg::EV_OK ||
          rsp_data.event_kind == dpr_pkg::EV_MISMATCH ||
          rsp_data.event_kind == dpr_pkg::EV_BAD_HEX ||
          rsp_data.event_kind == dpr_pkg::EV_OVERFLOW))
   else $error("reply_valid does not match event kind");

   // A payload byte has always been counted
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.event_kind == dpr_pkg::EV_PAYLOAD) |->
         (rsp_data.payload_length != '0))
   else $error("payload event with zero length");

   // Decoded checksum is only reported with the checksum verdict
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.event_kind != dpr_pkg::EV_OK &&
       rsp_data.event_kind != dpr_pkg::EV_MISMATCH) |-> (rsp_data.sum_received == 8'h00))
   else $error("sum_received set outside a checksum verdict");

   // The queue is empty straight after reset, so input is taken
   assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !req_stall)
   else $error("input stalled right after reset");

endmodule

`default_nettype wire

// ----- tb/debug_packet_receiver_test.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for debug_packet_receiver: directed and random byte/idle streams,
// predicted by an in-bench packet deframer. Depends on dpr_pkg and the receiver RTL.

module debug_packet_receiver_test;
   import dpr_pkg::*;

   localparam int RUN_LIMIT     = 1000000;
   localparam int SETTLE_CYCLES = 8;
   localparam int MAX_WAIT      = 13;
   localparam int PHASE_ITEMS   = 1850 / 8;
   localparam int REPORT_LIMIT  = 10;

   typedef enum {END_GOOD, END_WRONG, END_BAD_DIGIT, END_CUT} packet_end_type;

   logic                   clock     = 1'b0;
   logic                   reset     = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   req_type                req_data  = '0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   rsp_type                rsp_data;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;

   req_type                            pending_items[$];
   logic [CSR_INDEX_W+CSR_DATA_W-1:0]  pending_writes[$];
   rsp_type                            expected_events[$];

   // deframer state and register copies
   phase_type               rx_phase;
   logic [LENGTH_BITS-1:0]  rx_count;
   logic [7:0]              rx_sum;
   logic [7:0]              digit_acc;
   logic                    digit_half;
   logic [IDLE_BITS-1:0]    idle_run;
   logic [BUF_SIZE_W-1:0]   cfg_buffer_size;
   logic [IDLE_LIMIT_W-1:0] cfg_idle_limit;

   int      phase_buffer  = 1024;
   int      phase_idle    = 1000000;
   int      items_counted = 0;
   int      failures      = 0;
   int      cycle_count   = 0;
   int      send_wait     = 0;
   int      stall_wait    = 0;
   logic    send_burst    = 1'b0;
   logic    stall_burst   = 1'b0;
   rsp_type want;

   debug_packet_receiver u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #1 clock = ~clock;

   // Value of a hex digit in either case; bit 4 set when the byte is no hex digit
   function automatic logic [4:0] hex_nibble(input logic [7:0] c);
      if (c >= "0" && c <= "9") return 5'(c - "0");
      if (c >= "a" && c <= "f") return 5'(c - "a" + 8'd10);
      if (c >= "A" && c <= "F") return 5'(c - "A" + 8'd10);
      return 5'h10;
   endfunction

   function automatic logic [7:0] hex_char(input logic [3:0] nib, input logic upper);
      if (nib < 4'd10) return "0" + nib;
      return (upper ? "A" : "a") + nib - 8'd10;
   endfunction

   // Wait before the next transfer; bursts of zero waits come and go at random
   function automatic int draw_wait(inout logic burst);
      if ($urandom_range(0, 39) == 0) burst = ~burst;
      return burst ? 0 : $urandom_range(0, MAX_WAIT);
   endfunction

   function automatic string describe(input rsp_type r);
      return $sformatf("kind=%0d byte=%02h len=%0d reply=%0d/%02h sum=%02h rcvd=%02h",
                       r.event_kind, r.payload_byte, r.payload_length, r.reply_valid,
                       r.reply_byte, r.sum_computed, r.sum_received);
   endfunction

   task automatic restart_hunt();
      rx_phase   = PH_HUNT;
      rx_count   = '0;
      rx_sum     = '0;
      digit_acc  = '0;
      digit_half = 1'b0;
   endtask

   // Deframer: advances the state by one item and queues the event it raises
   task automatic predict_item(input req_type item);
      rsp_type               ev;
      logic                  fire;
      logic                  go_hunt;
      logic [BUF_SIZE_W-1:0] room;
      logic [4:0]            digit;
      ev      = '0;
      fire    = 1'b0;
      go_hunt = 1'b0;
      if (item.opcode == OP_IDLE) begin
         if (idle_run >= cfg_idle_limit) begin
            ev.event_kind = EV_TIMEOUT;
            fire          = 1'b1;
            go_hunt       = 1'b1;
            idle_run      = '0;
         end else begin
            idle_run = idle_run + 1'b1;
         end
      end else begin
         idle_run = '0;
         if (item.rx_byte == CTRL_C_CH) begin
            ev.event_kind = EV_INTERRUPT;
            fire          = 1'b1;
            go_hunt       = 1'b1;
         end else if (rx_phase == PH_DATA) begin
            room = (cfg_buffer_size == '0) ? '0 : cfg_buffer_size - 1'b1;
            if (room > LEN_MAX) room = LEN_MAX;
            if (item.rx_byte == END_CH) begin
               rx_phase   = PH_SUM;
               digit_half = 1'b0;
               digit_acc  = '0;
            end else if (rx_count < room) begin
               rx_count        = rx_count + 1'b1;
               rx_sum          = rx_sum + item.rx_byte;
               ev.event_kind   = EV_PAYLOAD;
               ev.payload_byte = item.rx_byte;
               fire            = 1'b1;
            end else begin
               ev.event_kind  = EV_OVERFLOW;
               ev.reply_valid = 1'b1;
               ev.reply_byte  = NACK_CH;
               fire           = 1'b1;
               go_hunt        = 1'b1;
            end
         end else if (rx_phase == PH_SUM) begin
            digit = hex_nibble(item.rx_byte);
            if (digit[4]) begin
               ev.event_kind  = EV_BAD_HEX;
               ev.reply_valid = 1'b1;
               ev.reply_byte  = NACK_CH;
               fire           = 1'b1;
               go_hunt        = 1'b1;
            end else begin
               digit_acc = {digit_acc[3:0], digit[3:0]};
               if (!digit_half) begin
                  digit_half = 1'b1;
               end else begin
                  ev.event_kind   = (digit_acc == rx_sum) ? EV_OK : EV_MISMATCH;
                  ev.reply_byte   = (digit_acc == rx_sum) ? ACK_CH : NACK_CH;
                  ev.reply_valid  = 1'b1;
                  ev.sum_received = digit_acc;
                  fire            = 1'b1;
                  go_hunt         = 1'b1;
               end
            end
         end else if (item.rx_byte == START_CH) begin
            restart_hunt();
            rx_phase = PH_DATA;
         end else begin
            rx_phase = PH_HUNT;
         end
      end
      if (fire) begin
         ev.payload_length = rx_count;
         ev.sum_computed   = rx_sum;
         expected_events.push_back(ev);
      end
      if (go_hunt) restart_hunt();
   endtask

   // Input driver: one item per transfer, random wait before each
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         restart_hunt();
         idle_run  = '0;
         send_wait = 0;
      end else begin
         if (req_valid && !req_stall) predict_item(req_data);
         if (!req_valid || !req_stall) begin
            if (send_wait > 0) begin
               send_wait--;
               req_valid <= 1'b0;
            end else if (pending_items.size() > 0) begin
               req_data  <= pending_items.pop_front();
               req_valid <= 1'b1;
               send_wait = draw_wait(send_burst);
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Register writes; the copies follow at the transfer edge
   always @(posedge clock) begin
      if (reset) begin
         csr_valid <= 1'b0;
         cfg_buffer_size = BUF_SIZE_RESET;
         cfg_idle_limit  = IDLE_LIMIT_RESET;
      end else begin
         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_BUFFER_SIZE) cfg_buffer_size = csr_wdata[BUF_SIZE_W-1:0];
            else if (csr_index == CSR_IDLE_LIMIT) cfg_idle_limit = csr_wdata[IDLE_LIMIT_W-1:0];
         end
         if (!csr_valid || csr_ready) begin
            if (pending_writes.size() > 0) begin
               {csr_index, csr_wdata} <= pending_writes.pop_front();
               csr_valid <= 1'b1;
            end else begin
               csr_valid <= 1'b0;
            end
         end
      end
   end

   // Result monitor: checks each transfer against the oldest expected event
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_wait = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_events.size() == 0) begin
               failures++;
               if (failures <= REPORT_LIMIT)
                  $display("unexpected result: %s", describe(rsp_data));
            end else begin
               want = expected_events.pop_front();
               if (rsp_data.event_kind !== want.event_kind
                   || rsp_data.payload_byte !== want.payload_byte
                   || rsp_data.payload_length !== want.payload_length
                   || rsp_data.reply_valid !== want.reply_valid
                   || rsp_data.reply_byte !== want.reply_byte
                   || rsp_data.sum_computed !== want.sum_computed
                   || rsp_data.sum_received !== want.sum_received) begin
                  failures++;
                  if (failures <= REPORT_LIMIT)
                     $display("mismatch: expected %s, got %s", describe(want),
                              describe(rsp_data));
               end
            end
            stall_wait = draw_wait(stall_burst);
         end
         if (stall_wait > 0) begin
            rsp_stall <= 1'b1;
            stall_wait--;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > RUN_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   task automatic queue_item(input opcode_type op, input logic [7:0] value,
                             input logic counts);
      req_type item;
      item.opcode  = op;
      item.rx_byte = value;
      pending_items.push_back(item);
      if (counts) items_counted++;
   endtask

   task automatic queue_text(input string text);
      for (int i = 0; i < text.len(); i++) queue_item(OP_BYTE, text[i], 1'b1);
   endtask

   // One packet with random payload; the ending picks checksum, error or truncation
   task automatic queue_packet(input int len, input packet_end_type ending);
      logic [7:0] sum;
      logic [7:0] value;
      logic [7:0] check;
      logic [4:0] digit;
      sum = '0;
      queue_item(OP_BYTE, START_CH, 1'b1);
      repeat (len) begin
         if ($urandom_range(0, 7) == 0) queue_item(OP_IDLE, 8'($urandom), 1'b1);
         value = 8'($urandom);
         sum   = sum + value;
         queue_item(OP_BYTE, value, 1'b1);
      end
      if (ending == END_CUT) return;
      queue_item(OP_BYTE, END_CH, 1'b1);
      check = (ending == END_WRONG) ? sum ^ 8'($urandom_range(1, 255)) : sum;
      if (ending == END_BAD_DIGIT) begin
         if ($urandom_range(0, 1))
            queue_item(OP_BYTE, hex_char(check[7:4], 1'($urandom)), 1'b1);
         do begin
            value = 8'($urandom);
            digit = hex_nibble(value);
         end while (!digit[4]);
         queue_item(OP_BYTE, value, 1'b1);
      end else begin
         queue_item(OP_BYTE, hex_char(check[7:4], 1'($urandom)), 1'b1);
         queue_item(OP_BYTE, hex_char(check[3:0], 1'($urandom)), 1'b1);
      end
   endtask

   // Sender holds off until every event is in and the pipeline has drained
   task automatic wait_quiet();
      do @(negedge clock);
      while (pending_items.size() != 0 || req_valid || expected_events.size() != 0);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic configure(input int buffer_size, input int idle_limit);
      wait_quiet();
      pending_writes.push_back({CSR_BUFFER_SIZE, CSR_DATA_W'(buffer_size)});
      pending_writes.push_back({CSR_IDLE_LIMIT, CSR_DATA_W'(idle_limit)});
      do @(negedge clock);
      while (pending_writes.size() != 0 || csr_valid);
      phase_buffer = buffer_size;
      phase_idle   = idle_limit;
   endtask

   // Mostly well-formed packets, mixed with idle runs, noise and interrupts
   task automatic run_random_phase(input int quota);
      int             goal;
      int             pick;
      int             len;
      int             room;
      packet_end_type ending;
      goal = items_counted + quota;
      room = phase_buffer - 1;
      while (items_counted < goal) begin
         pick = $urandom_range(0, 99);
         if (pick < 60) begin
            if (room <= 24 && $urandom_range(0, 4) == 0) begin
               len    = room + 1;
               ending = END_CUT;
            end else begin
               len  = $urandom_range(0, (room < 12) ? room : 12);
               pick = $urandom_range(0, 99);
               if (pick < 70) ending = END_GOOD;
               else if (pick < 82) ending = END_WRONG;
               else if (pick < 92) ending = END_BAD_DIGIT;
               else ending = END_CUT;
            end
            queue_packet(len, ending);
         end else if (pick < 75) begin
            repeat ($urandom_range(1, (phase_idle < 20) ? phase_idle + 2 : 20))
               queue_item(OP_IDLE, 8'($urandom), 1'b1);
         end else if (pick < 85) begin
            repeat ($urandom_range(1, 3)) queue_item(OP_BYTE, 8'($urandom), 1'b0);
         end else if (pick < 90) begin
            queue_item(OP_BYTE, CTRL_C_CH, 1'b1);
         end else if (pick < 95) begin
            queue_item(OP_BYTE, $urandom_range(0, 1) ? ACK_CH : NACK_CH, 1'b0);
         end else begin
            repeat ($urandom_range(1, 4))
               queue_item(opcode_type'($urandom_range(0, 1)), 8'($urandom), 1'b1);
         end
      end
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // directed, reset settings: framing, both cases, errors, interrupts
      queue_text("+x");
      queue_item(OP_BYTE, START_CH, 1'b1);
      queue_item(OP_BYTE, 8'h00, 1'b1);
      queue_item(OP_BYTE, 8'hFF, 1'b1);
      queue_text("#fF");
      queue_text("$A#4a");
      queue_text("$#G");
      queue_text("$$");
      queue_item(OP_BYTE, CTRL_C_CH, 1'b1);
      queue_text("$#");
      queue_item(OP_BYTE, CTRL_C_CH, 1'b1);
      queue_item(OP_BYTE, CTRL_C_CH, 1'b1);
      queue_text("$#00");
      queue_item(OP_IDLE, 8'hFF, 1'b1);

      // buffer size 2 overflows on the second payload byte; zero idle limit times out at once
      configure(2, 0);
      queue_text("$ab#");
      queue_item(OP_IDLE, 8'h00, 1'b1);
      queue_item(OP_IDLE, 8'hFF, 1'b1);

      configure(2, 0);
      run_random_phase(PHASE_ITEMS);
      configure(4096, 1048575);
      run_random_phase(PHASE_ITEMS);
      configure(3, 1);
      run_random_phase(PHASE_ITEMS);
      configure(1024, 1000000);
      run_random_phase(PHASE_ITEMS);
      configure(9, 5);
      run_random_phase(PHASE_ITEMS);
      configure(64, 13);
      run_random_phase(PHASE_ITEMS);
      configure($urandom_range(2, 4096), $urandom_range(0, 40));
      run_random_phase(PHASE_ITEMS);
      configure($urandom_range(2, 30), $urandom_range(0, 8));
      run_random_phase(PHASE_ITEMS);

      wait_quiet();
      if (failures == 0 && expected_events.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

// ----- files.f -----
hw/rtl/dpr_pkg.sv
hw/rtl/dpr_front.sv
hw/rtl/dpr_queue.sv
hw/rtl/dpr_back.sv
hw/rtl/debug_packet_receiver.sv
tb/debug_packet_receiver_test.sv
